/* rtl/blot_pkg.sv */
// Package: shared constants, codes and defaults for the block layout offset translator.
package blot_pkg;

  localparam int CFG_W            = 32;
  localparam int FULL_W           = 34;
  localparam int DEF_OFFSET_WIDTH = 48;
  localparam int DEF_LENGTH_WIDTH = 32;
  localparam int ADDR_W           = 2;
  localparam int FUNC_W           = 2;
  localparam int STATUS_W         = 2;

  localparam logic [CFG_W-1:0] HEADER_RESET  = 32'd4096;
  localparam logic [CFG_W-1:0] PAYLOAD_RESET = 32'd4032;
  localparam logic [CFG_W-1:0] BLOCK_RESET   = 32'd4096;

  localparam logic [ADDR_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_PAYLOAD = 2'd1;
  localparam logic [ADDR_W-1:0] REG_BLOCK   = 2'd2;

  localparam logic [FUNC_W-1:0] FUNC_P2L   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_L2P   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADCFG   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

endpackage

/* rtl/blot_if.sv */
// Interfaces: configuration, request and response channels.
interface blot_cfg_if import blot_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [CFG_W-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

interface blot_req_if import blot_pkg::*; #(
  parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH,
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic [FUNC_W-1:0]              func;
  logic signed [OFFSET_WIDTH-1:0] offset;
  logic [LENGTH_WIDTH-1:0]        byte_count;
  modport source (output valid, func, offset, byte_count, input ready);
  modport sink   (input valid, func, offset, byte_count, output ready);
endinterface

interface blot_rsp_if import blot_pkg::*; #(
  parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [OFFSET_WIDTH-1:0] translated_offset;
  logic [CFG_W-1:0]        first_partial_bytes;
  logic [CFG_W-1:0]        last_partial_bytes;
  logic [FULL_W-1:0]       full_block_bytes;
  modport source (output valid, status, translated_offset, first_partial_bytes,
                  last_partial_bytes, full_block_bytes, input ready);
  modport sink   (input valid, status, translated_offset, first_partial_bytes,
                  last_partial_bytes, full_block_bytes, output ready);
endinterface

/* rtl/blot_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module blot_div import blot_pkg::*; #(
  parameter int DVW = DEF_OFFSET_WIDTH + 1,
  parameter int SW  = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DVW-1:0]   dividend,
  input  logic [CFG_W-1:0] divisor,
  input  logic [SW-1:0]    side_in,
  output logic             out_valid,
  output logic [DVW-1:0]   quot,
  output logic [CFG_W-1:0] rem,
  output logic [SW-1:0]    side_out
);

  logic             vld [DVW+1];
  logic [CFG_W-1:0] rm  [DVW+1];
  logic [DVW-1:0]   dd  [DVW+1];
  logic [DVW-1:0]   qq  [DVW+1];
  logic [CFG_W-1:0] dv  [DVW+1];
  logic [SW-1:0]    sd  [DVW+1];

  assign vld[0] = in_valid;
  assign rm[0]  = '0;
  assign dd[0]  = dividend;
  assign qq[0]  = '0;
  assign dv[0]  = divisor;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < DVW; k++) begin : g_stage
    logic [CFG_W:0] t;
    logic [CFG_W:0] diff;
    logic           ge;
    assign t    = {rm[k], dd[k][DVW-1]};
    assign diff = t - {1'b0, dv[k]};
    assign ge   = t >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= ge ? diff[CFG_W-1:0] : t[CFG_W-1:0];
        dd[k+1] <= dd[k] << 1;
        qq[k+1] <= {qq[k][DVW-2:0], ge};
        dv[k+1] <= dv[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[DVW];
  assign quot      = qq[DVW];
  assign rem       = rm[DVW];
  assign side_out  = sd[DVW];

endmodule

/* rtl/block_layout_offset_translator_core.sv */
// Top level: block layout offset translator, pipelined over a shared-depth divider.
// The pipeline is an input register, max(OFFSET_WIDTH,LENGTH_WIDTH)+1 divider stages,
// a multiply stage and a sum stage into the output register, with the divider taking one
// quotient bit per stage; one beat per cycle is accepted in steady state and the whole
// pipeline holds while the output register waits on ready.
// Configuration writes take effect for beats accepted after the write.
module block_layout_offset_translator_core import blot_pkg::*; #(
  parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH,
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  blot_cfg_if.sink  cfg,
  blot_req_if.sink  req,
  blot_rsp_if.source rsp
);

  localparam int OW  = OFFSET_WIDTH;
  localparam int LW  = LENGTH_WIDTH;
  localparam int DVW = ((OW > LW) ? OW : LW) + 1;
  localparam int QW  = OW - 1;
  localparam int HW  = (QW + 1) / 2;
  localparam int PW  = QW + CFG_W + 1;
  localparam int SW  = FUNC_W + 1 + STATUS_W + 3 * CFG_W + LW;

  logic [CFG_W-1:0] header_length, payload_length, block_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_length  <= HEADER_RESET;
      payload_length <= PAYLOAD_RESET;
      block_length   <= BLOCK_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_HEADER:  header_length  <= cfg.data;
        REG_PAYLOAD: payload_length <= cfg.data;
        REG_BLOCK:   block_length   <= cfg.data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // input stage
  logic              s0_valid;
  logic [FUNC_W-1:0] s0_func;
  logic [OW-1:0]     s0_raw;
  logic [LW-1:0]     s0_count;
  logic [CFG_W-1:0]  s0_h, s0_p, s0_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_func  <= req.func;
      s0_raw   <= req.offset;
      s0_count <= req.byte_count;
      s0_h     <= header_length;
      s0_p     <= payload_length;
      s0_b     <= block_length;
    end
  end

  logic                s0_badcfg, s0_neg, s0_lt, s0_err;
  logic [STATUS_W-1:0] s0_est;
  logic [63:0]         s0_rel, s0_sumb;
  logic [DVW-1:0]      a_dividend, b_dividend;
  logic [CFG_W-1:0]    a_divisor;
  logic [SW-1:0]       s0_side;

  always_comb begin
    s0_badcfg = (s0_h == '0) || (s0_p == '0) || (s0_b == '0) || (s0_p >= s0_b);
    s0_neg    = s0_raw[OW-1];
    s0_lt     = 64'(s0_raw) < 64'(s0_h);
    s0_err    = 1'b1;
    s0_est    = ST_INVALID;
    if (s0_badcfg) begin
      s0_est = ST_BADCFG;
    end else if (s0_func == FUNC_NONE || s0_neg) begin
      s0_est = ST_INVALID;
    end else if (s0_func == FUNC_P2L && s0_lt) begin
      s0_est = ST_INVALID;
    end else begin
      s0_err = 1'b0;
      s0_est = ST_OK;
    end
    s0_rel     = 64'(s0_raw) - 64'(s0_h);
    s0_sumb    = 64'(s0_raw) + 64'(s0_count);
    a_dividend = (s0_func == FUNC_P2L) ? s0_rel[DVW-1:0] : DVW'(s0_raw);
    a_divisor  = (s0_func == FUNC_P2L) ? s0_b : s0_p;
    b_dividend = s0_sumb[DVW-1:0];
    s0_side    = {s0_func, s0_err, s0_est, s0_h, s0_p,
                  (s0_func == FUNC_P2L) ? s0_p : s0_b, s0_count};
  end

  logic             d_valid;
  logic [DVW-1:0]   d_quot;
  logic [CFG_W-1:0] d_rem_a, d_rem_b;
  logic [SW-1:0]    d_side;

  blot_div #(.DVW(DVW), .SW(SW)) u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_valid),
    .dividend(a_dividend), .divisor(a_divisor), .side_in(s0_side),
    .out_valid(d_valid), .quot(d_quot), .rem(d_rem_a), .side_out(d_side)
  );

  blot_div #(.DVW(DVW), .SW(1)) u_div_b (
    .clk(clk), .rst(rst), .en(en), .in_valid(1'b0),
    .dividend(b_dividend), .divisor(s0_p), .side_in(1'b0),
    .out_valid(), .quot(), .rem(d_rem_b), .side_out()
  );

  // multiply stage
  logic [FUNC_W-1:0]   d_func;
  logic                d_err;
  logic [STATUS_W-1:0] d_est;
  logic [CFG_W-1:0]    d_h, d_p, d_m;
  logic [LW-1:0]       d_count;
  logic [QW-1:0]       d_q;
  logic [CFG_W-1:0]    d_first, d_last;
  logic                d_big;
  logic [63:0]         d_rest_w;

  assign {d_func, d_err, d_est, d_h, d_p, d_m, d_count} = d_side;
  assign d_q = d_quot[QW-1:0];

  always_comb begin
    d_first  = (d_rem_a != '0) ? (d_p - d_rem_a) : '0;
    d_big    = 64'(d_first) >= 64'(d_count);
    d_rest_w = 64'(d_count) - 64'(d_first);
  end

  logic                m_valid;
  logic [FUNC_W-1:0]   m_func;
  logic                m_err;
  logic [STATUS_W-1:0] m_est;
  logic [HW+CFG_W-1:0] m_plo;
  logic [QW-HW+CFG_W-1:0] m_phi;
  logic [CFG_W:0]      m_addend;
  logic [CFG_W-1:0]    m_p, m_first, m_last;
  logic [LW-1:0]       m_rest;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_func   <= d_func;
      m_err    <= d_err || (d_func == FUNC_P2L && d_rem_a >= d_p);
      m_est    <= d_err ? d_est : ST_INVALID;
      m_plo    <= (HW+CFG_W)'(d_q[HW-1:0]) * (HW+CFG_W)'(d_m);
      m_phi    <= (QW-HW+CFG_W)'(d_q[QW-1:HW]) * (QW-HW+CFG_W)'(d_m);
      m_addend <= (d_func == FUNC_P2L) ? (CFG_W+1)'(d_rem_a)
                                        : (CFG_W+1)'(d_h) + (CFG_W+1)'(d_rem_a);
      m_p      <= d_p;
      m_first  <= d_big ? d_count[CFG_W-1:0] : d_first;
      m_last   <= d_big ? '0 : d_rem_b;
      m_rest   <= d_big ? '0 : d_rest_w[LW-1:0];
    end
  end

  // sum stage into output register
  logic [PW-1:0]       sum;
  logic [63:0]         total;
  logic                ovf_off, ovf_cnt;
  logic [STATUS_W-1:0] st;

  always_comb begin
    sum     = (PW'(m_phi) << HW) + PW'(m_plo) + PW'(m_addend);
    ovf_off = |sum[PW-1:OW-1];
    total   = 64'(m_rest) - 64'(m_last) + ((m_first != '0) ? 64'(m_p) : 64'd0)
              + ((m_last != '0) ? 64'(m_p) : 64'd0);
    ovf_cnt = |total[63:FULL_W];
    if (m_err) begin
      st = m_est;
    end else begin
      case (m_func)
        FUNC_P2L, FUNC_L2P: st = ovf_off ? ST_OVERFLOW : ST_OK;
        FUNC_RANGE:         st = ovf_cnt ? ST_OVERFLOW : ST_OK;
        default:            st = ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.status              <= st;
      rsp.translated_offset   <= (st == ST_OK && m_func != FUNC_RANGE) ? sum[OW-1:0] : '0;
      rsp.first_partial_bytes <= (st == ST_OK && m_func == FUNC_RANGE) ? m_first : '0;
      rsp.last_partial_bytes  <= (st == ST_OK && m_func == FUNC_RANGE) ? m_last : '0;
      rsp.full_block_bytes    <= (st == ST_OK && m_func == FUNC_RANGE) ? total[FULL_W-1:0]
                                                                        : '0;
    end
  end

endmodule
